[hdl/bgfr_pkg.sv]
// Shared types and constants for the binary GPS frame receiver.
// No dependencies; used by every module under hdl.
package bgfr_pkg;

    localparam logic [7:0]  SYNC_FIRST_RST  = 8'd181;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'd98;
    localparam logic [15:0] MAX_LENGTH_RST  = 16'd512;

    typedef enum logic [1:0] {
        REG_SYNC_FIRST  = 2'd0,
        REG_SYNC_SECOND = 2'd1,
        REG_MAX_LENGTH  = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        PH_HUNT     = 4'd0,
        PH_SYNC2    = 4'd1,
        PH_CLASS    = 4'd2,
        PH_ID       = 4'd3,
        PH_LEN_LO   = 4'd4,
        PH_LEN_HI   = 4'd5,
        PH_PAYLOAD  = 4'd6,
        PH_CHECK_A  = 4'd7,
        PH_CHECK_B  = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_GOOD    = 3'd2,
        EV_BAD_A   = 3'd3,
        EV_BAD_B   = 3'd4,
        EV_LEN_REJ = 3'd5
    } event_t;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] max_length;
    } cfg_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
    } result_t;

endpackage

[hdl/bgfr_fsm.sv]
// Frame state machine: phase, Fletcher sums, header capture and result logic.
// Depends on bgfr_pkg.
module bgfr_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  bgfr_pkg::cfg_t    cfg,
    output bgfr_pkg::result_t res
);

    bgfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;

    logic [7:0]  acc_a;
    logic [7:0]  acc_b;
    logic [15:0] full_len;
    logic [15:0] count_inc;
    logic [15:0] shown_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= bgfr_pkg::PH_HUNT;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            class_reg  <= '0;
            id_reg     <= '0;
            length_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            class_reg  <= class_next;
            id_reg     <= id_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

    assign acc_a     = sum_a_reg + rx_byte;
    assign acc_b     = sum_b_reg + acc_a;
    assign full_len  = {rx_byte, length_reg[7:0]};
    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        sum_a_next        = sum_a_reg;
        sum_b_next        = sum_b_reg;
        class_next        = class_reg;
        id_next           = id_reg;
        length_next       = length_reg;
        count_next        = count_reg;
        shown_len         = '0;
        res.event_res     = bgfr_pkg::EV_NONE;
        res.payload_byte  = '0;
        res.payload_index = '0;
        case (phase_reg)
            bgfr_pkg::PH_SYNC2:
            begin
                if (rx_byte == cfg.sync_second)
                    phase_next = bgfr_pkg::PH_CLASS;
                else if (rx_byte == cfg.sync_first)
                    phase_next = bgfr_pkg::PH_SYNC2;
                else
                    phase_next = bgfr_pkg::PH_HUNT;
            end
            bgfr_pkg::PH_CLASS:
            begin
                class_next = rx_byte;
                sum_a_next = rx_byte;
                sum_b_next = rx_byte;
                phase_next = bgfr_pkg::PH_ID;
            end
            bgfr_pkg::PH_ID:
            begin
                sum_a_next = acc_a;
                sum_b_next = acc_b;
                id_next    = rx_byte;
                phase_next = bgfr_pkg::PH_LEN_LO;
            end
            bgfr_pkg::PH_LEN_LO:
            begin
                sum_a_next  = acc_a;
                sum_b_next  = acc_b;
                length_next = {8'd0, rx_byte};
                phase_next  = bgfr_pkg::PH_LEN_HI;
            end
            bgfr_pkg::PH_LEN_HI:
            begin
                sum_a_next  = acc_a;
                sum_b_next  = acc_b;
                length_next = full_len;
                count_next  = '0;
                if (full_len > cfg.max_length)
                begin
                    res.event_res = bgfr_pkg::EV_LEN_REJ;
                    length_next   = '0;
                    phase_next    = bgfr_pkg::PH_HUNT;
                end
                else if (full_len == 16'd0)
                    phase_next = bgfr_pkg::PH_CHECK_A;
                else
                    phase_next = bgfr_pkg::PH_PAYLOAD;
            end
            bgfr_pkg::PH_PAYLOAD:
            begin
                sum_a_next        = acc_a;
                sum_b_next        = acc_b;
                res.event_res     = bgfr_pkg::EV_PAYLOAD;
                res.payload_byte  = rx_byte;
                res.payload_index = count_reg;
                count_next        = count_inc;
                if (count_inc == length_reg)
                    phase_next = bgfr_pkg::PH_CHECK_A;
            end
            bgfr_pkg::PH_CHECK_A:
            begin
                if (rx_byte == sum_a_reg)
                    phase_next = bgfr_pkg::PH_CHECK_B;
                else
                begin
                    res.event_res = bgfr_pkg::EV_BAD_A;
                    phase_next    = bgfr_pkg::PH_HUNT;
                end
            end
            bgfr_pkg::PH_CHECK_B:
            begin
                res.event_res = (rx_byte == sum_b_reg) ? bgfr_pkg::EV_GOOD
                                                       : bgfr_pkg::EV_BAD_B;
                phase_next    = bgfr_pkg::PH_HUNT;
            end
            default:
            begin
                phase_next = (rx_byte == cfg.sync_first) ? bgfr_pkg::PH_SYNC2
                                                         : bgfr_pkg::PH_HUNT;
            end
        endcase
        // show the rejected length once, before it is cleared
        shown_len        = (res.event_res == bgfr_pkg::EV_LEN_REJ) ? full_len
                                                                  : length_next;
        res.frame_class  = class_next;
        res.frame_id     = id_next;
        res.frame_length = shown_len;
    end

    a_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bgfr_pkg::PH_PAYLOAD |-> count_reg < length_reg)
        else $error("payload count reached frame length inside payload");

    a_bad_a_rehunts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == bgfr_pkg::PH_CHECK_A && rx_byte != sum_a_reg
        |=> phase_reg == bgfr_pkg::PH_HUNT)
        else $error("bad first checksum did not restart hunting");

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == bgfr_pkg::PH_LEN_HI |=> count_reg == 16'd0)
        else $error("payload count not cleared after length");

endmodule

[hdl/bgfr_outreg.sv]
// Result register between the state machine and the output stream.
// Depends on bgfr_pkg.
module bgfr_outreg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bgfr_pkg::result_t in_res,
    output logic              out_valid,
    input  logic              out_ready,
    output bgfr_pkg::result_t out_res
);

    logic              valid_reg, valid_next;
    bgfr_pkg::result_t res_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            res_reg <= in_res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

[hdl/binary_gps_frame_receiver_core.sv]
// Top level of the binary GPS frame receiver: configuration registers and streams.
// Depends on bgfr_pkg, bgfr_fsm and bgfr_outreg.
//
// One received byte per request, one result per byte. A byte is taken every
// cycle while the result register is empty or its result is being taken in
// the same cycle; the result appears in the cycle after the byte is accepted.
// The frame state machine with its Fletcher adders and length compare feeds
// the result register combinationally. Configuration writes are accepted
// every cycle and take effect on the next byte; writes to index 3 are ignored.
module binary_gps_frame_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,     // [7:0] frame_class, [15:8] frame_id,
                                     // [31:16] frame_length, [39:32] payload_byte,
                                     // [55:40] payload_index
    output logic [2:0]  m_tuser,     // [2:0] event_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    bgfr_pkg::cfg_t    cfg_reg;
    bgfr_pkg::result_t fsm_res;
    bgfr_pkg::result_t out_res;
    logic              accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= bgfr_pkg::SYNC_FIRST_RST;
            cfg_reg.sync_second <= bgfr_pkg::SYNC_SECOND_RST;
            cfg_reg.max_length  <= bgfr_pkg::MAX_LENGTH_RST;
        end
        else if (cfg_valid)
        begin
            case (bgfr_pkg::reg_idx_t'(cfg_index))
                bgfr_pkg::REG_SYNC_FIRST:  cfg_reg.sync_first  <= cfg_data[7:0];
                bgfr_pkg::REG_SYNC_SECOND: cfg_reg.sync_second <= cfg_data[7:0];
                bgfr_pkg::REG_MAX_LENGTH:  cfg_reg.max_length  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    bgfr_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .cfg     (cfg_reg),
        .res     (fsm_res)
    );

    bgfr_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (fsm_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.event_res;
    assign m_tdata = {out_res.payload_index, out_res.payload_byte, out_res.frame_length,
                      out_res.frame_id, out_res.frame_class};

endmodule

[test/binary_gps_frame_receiver_core_tb.sv]
// Self-checking bench for binary_gps_frame_receiver_core: sync hunt, header capture,
// payload streaming, Fletcher checks and length rejection under random idling.
// Depends on bgfr_pkg and the RTL under hdl; reads no files.
module binary_gps_frame_receiver_core_tb;

    localparam int unsigned IDLE_LIMIT     = 2000;
    localparam int unsigned BYTES_PER_PASS = 300;
    localparam int unsigned SETTINGS_COUNT = 6;

    typedef struct {
        logic [7:0]          rx;
        bit                  fixed;
        bgfr_pkg::result_t   res;
    } rx_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // register copies as the block should hold them
    logic [7:0]  cfg_sync1 = bgfr_pkg::SYNC_FIRST_RST;
    logic [7:0]  cfg_sync2 = bgfr_pkg::SYNC_SECOND_RST;
    logic [15:0] cfg_max   = bgfr_pkg::MAX_LENGTH_RST;

    // frame tracker state
    bgfr_pkg::phase_t rx_phase = bgfr_pkg::PH_HUNT;
    logic [7:0]  fl_a      = '0;
    logic [7:0]  fl_b      = '0;
    logic [7:0]  cur_class = '0;
    logic [7:0]  cur_id    = '0;
    logic [15:0] cur_len   = '0;
    logic [15:0] pay_count = '0;

    bgfr_pkg::result_t frame_results_q[$];
    bit          no_idle = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned bytes_sent = 0;
    int unsigned payload_seen = 0;
    int unsigned good_seen = 0;
    int unsigned bad_a_seen = 0;
    int unsigned bad_b_seen = 0;
    int unsigned rejected_seen = 0;

    binary_gps_frame_receiver_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic rx_row_t dir_row(input logic [7:0] rx, input bit fixed,
                                        input bgfr_pkg::event_t ev,
                                        input logic [7:0] cls, input logic [7:0] id,
                                        input logic [15:0] len);
        rx_row_t r;
        r.rx  = rx;
        r.fixed = fixed;
        r.res = '{event_res: ev, frame_class: cls, frame_id: id, frame_length: len,
                  payload_byte: 8'd0, payload_index: 16'd0};
        return r;
    endfunction

    // advance the frame tracker by one received byte
    task automatic frame_track(input logic [7:0] b, output bgfr_pkg::result_t r);
        logic [15:0] shown_len;
        bit          shown_set;
        r = '{event_res: bgfr_pkg::EV_NONE, default: '0};
        shown_len = '0;
        shown_set = 1'b0;
        case (rx_phase)
            bgfr_pkg::PH_SYNC2:
            begin
                if (b == cfg_sync2)
                    rx_phase = bgfr_pkg::PH_CLASS;
                else
                    rx_phase = (b == cfg_sync1) ? bgfr_pkg::PH_SYNC2 : bgfr_pkg::PH_HUNT;
            end
            bgfr_pkg::PH_CLASS:
            begin
                cur_class = b;
                fl_a = b;
                fl_b = b;
                rx_phase = bgfr_pkg::PH_ID;
            end
            bgfr_pkg::PH_ID:
            begin
                fl_a = fl_a + b;
                fl_b = fl_b + fl_a;
                cur_id = b;
                rx_phase = bgfr_pkg::PH_LEN_LO;
            end
            bgfr_pkg::PH_LEN_LO:
            begin
                fl_a = fl_a + b;
                fl_b = fl_b + fl_a;
                cur_len = {8'h00, b};
                rx_phase = bgfr_pkg::PH_LEN_HI;
            end
            bgfr_pkg::PH_LEN_HI:
            begin
                fl_a = fl_a + b;
                fl_b = fl_b + fl_a;
                cur_len = {b, cur_len[7:0]};
                pay_count = '0;
                if (cur_len > cfg_max)
                begin
                    r.event_res = bgfr_pkg::EV_LEN_REJ;
                    shown_len = cur_len;
                    shown_set = 1'b1;
                    cur_len = '0;
                    rx_phase = bgfr_pkg::PH_HUNT;
                end
                else if (cur_len == 16'd0)
                    rx_phase = bgfr_pkg::PH_CHECK_A;
                else
                    rx_phase = bgfr_pkg::PH_PAYLOAD;
            end
            bgfr_pkg::PH_PAYLOAD:
            begin
                fl_a = fl_a + b;
                fl_b = fl_b + fl_a;
                r.event_res = bgfr_pkg::EV_PAYLOAD;
                r.payload_byte = b;
                r.payload_index = pay_count;
                pay_count = pay_count + 16'd1;
                if (pay_count == cur_len)
                    rx_phase = bgfr_pkg::PH_CHECK_A;
            end
            bgfr_pkg::PH_CHECK_A:
            begin
                if (b == fl_a)
                    rx_phase = bgfr_pkg::PH_CHECK_B;
                else
                begin
                    r.event_res = bgfr_pkg::EV_BAD_A;
                    rx_phase = bgfr_pkg::PH_HUNT;
                end
            end
            bgfr_pkg::PH_CHECK_B:
            begin
                r.event_res = (b == fl_b) ? bgfr_pkg::EV_GOOD : bgfr_pkg::EV_BAD_B;
                rx_phase = bgfr_pkg::PH_HUNT;
            end
            default:
                rx_phase = (b == cfg_sync1) ? bgfr_pkg::PH_SYNC2 : bgfr_pkg::PH_HUNT;
        endcase
        r.frame_class  = cur_class;
        r.frame_id     = cur_id;
        r.frame_length = shown_set ? shown_len : cur_len;
    endtask

    task automatic send_rx(input logic [7:0] b, input bit fixed,
                           input bgfr_pkg::result_t fixed_res);
        int unsigned       gap;
        bgfr_pkg::result_t r;
        gap = pick_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        frame_track(b, r);
        frame_results_q.push_back(fixed ? fixed_res : r);
        bytes_sent++;
    endtask

    task automatic write_reg(input bgfr_pkg::reg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            bgfr_pkg::REG_SYNC_FIRST:  cfg_sync1 = value[7:0];
            bgfr_pkg::REG_SYNC_SECOND: cfg_sync2 = value[7:0];
            bgfr_pkg::REG_MAX_LENGTH:  cfg_max   = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one whole frame (its length or checks may be bad), a burst of noise or a broken frame
    task automatic random_burst();
        int unsigned kind;
        int unsigned roll;
        int unsigned len;
        int unsigned max_i;
        int unsigned cut;
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        logic [7:0]  seq[$];
        kind  = $urandom_range(0, 99);
        max_i = 32'(cfg_max);
        if (kind >= 72 && kind < 86)
        begin
            repeat ($urandom_range(1, 5))
                seq.push_back(($urandom_range(0, 3) == 0) ? cfg_sync1 : 8'($urandom));
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10 && max_i != 65535)
                len = $urandom_range(65535, max_i + 1);
            else if (roll < 16 && max_i <= 64)
                len = max_i;
            else if (roll < 22)
                len = $urandom_range(0, (max_i < 64) ? max_i : 64);
            else
                len = $urandom_range(0, (max_i < 12) ? max_i : 12);
            seq.push_back(cfg_sync1);
            seq.push_back(cfg_sync2);
            seq.push_back(8'($urandom));
            seq.push_back(8'($urandom));
            seq.push_back(len[7:0]);
            seq.push_back(len[15:8]);
            if (len <= max_i)
            begin
                repeat (len) seq.push_back(8'($urandom));
                ck_a = '0;
                ck_b = '0;
                for (int i = 2; i < seq.size(); i++)
                begin
                    ck_a = ck_a + seq[i];
                    ck_b = ck_b + ck_a;
                end
                if ($urandom_range(0, 99) < 8)
                    ck_a = ck_a ^ 8'($urandom_range(1, 255));
                if ($urandom_range(0, 99) < 8)
                    ck_b = ck_b ^ 8'($urandom_range(1, 255));
                seq.push_back(ck_a);
                seq.push_back(ck_b);
            end
            if (kind >= 86)
            begin
                if ($urandom_range(0, 2) == 0)
                    seq[1] = 8'($urandom);
                cut = $urandom_range(1, seq.size() - 1);
                while (seq.size() > cut)
                    void'(seq.pop_back());
            end
        end
        foreach (seq[i])
            send_rx(seq[i], 1'b0, '0);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < 40)
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     results_seen, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        bgfr_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_results_q.size() == 0)
                report_mismatch("result with no request pending, event", 16'(m_tuser),
                                16'd0);
            else
            begin
                want = frame_results_q.pop_front();
                if (m_tuser !== want.event_res)
                    report_mismatch("event_res", 16'(m_tuser), 16'(want.event_res));
                if (m_tdata[7:0] !== want.frame_class)
                    report_mismatch("frame_class", 16'(m_tdata[7:0]),
                                    16'(want.frame_class));
                if (m_tdata[15:8] !== want.frame_id)
                    report_mismatch("frame_id", 16'(m_tdata[15:8]), 16'(want.frame_id));
                if (m_tdata[31:16] !== want.frame_length)
                    report_mismatch("frame_length", m_tdata[31:16], want.frame_length);
                if (m_tdata[39:32] !== want.payload_byte)
                    report_mismatch("payload_byte", 16'(m_tdata[39:32]),
                                    16'(want.payload_byte));
                if (m_tdata[55:40] !== want.payload_index)
                    report_mismatch("payload_index", m_tdata[55:40], want.payload_index);
                case (want.event_res)
                    bgfr_pkg::EV_PAYLOAD: payload_seen++;
                    bgfr_pkg::EV_GOOD:    good_seen++;
                    bgfr_pkg::EV_BAD_A:   bad_a_seen++;
                    bgfr_pkg::EV_BAD_B:   bad_b_seen++;
                    bgfr_pkg::EV_LEN_REJ: rejected_seen++;
                    default: ;
                endcase
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
                $display("binary_gps_frame_receiver_core_tb failed");
                $finish;
            end
        end
    end

    initial
    begin : drain_results
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall != 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge clk);
        end
    end

    initial
    begin : stimulus
        rx_row_t     dir_rows[25];
        logic [7:0]  sync1_set[SETTINGS_COUNT];
        logic [7:0]  sync2_set[SETTINGS_COUNT];
        logic [15:0] max_set[SETTINGS_COUNT];
        int unsigned pass_end;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = bgfr_pkg::REG_SYNC_FIRST;
        cfg_data  = '0;

        // hunt, retried first sync, all-ones header with rejected length,
        // zero-length frame with bad first check, two-byte frame with bad second check
        dir_rows = '{
            dir_row(8'h00, 1'b1, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'd181, 1'b1, bgfr_pkg::EV_NONE,   8'h00, 8'h00, 16'd0),
            dir_row(8'd181, 1'b1, bgfr_pkg::EV_NONE,   8'h00, 8'h00, 16'd0),
            dir_row(8'd98, 1'b1, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'hFF, 1'b1, bgfr_pkg::EV_NONE,    8'hFF, 8'h00, 16'd0),
            dir_row(8'hFF, 1'b1, bgfr_pkg::EV_NONE,    8'hFF, 8'hFF, 16'd0),
            dir_row(8'hFF, 1'b1, bgfr_pkg::EV_NONE,    8'hFF, 8'hFF, 16'h00FF),
            dir_row(8'hFF, 1'b1, bgfr_pkg::EV_LEN_REJ, 8'hFF, 8'hFF, 16'hFFFF),
            dir_row(8'd181, 1'b0, bgfr_pkg::EV_NONE,   8'h00, 8'h00, 16'd0),
            dir_row(8'd98, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'h01, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'h02, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'h00, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'h00, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'h00, 1'b1, bgfr_pkg::EV_BAD_A,   8'h01, 8'h02, 16'd0),
            dir_row(8'd181, 1'b0, bgfr_pkg::EV_NONE,   8'h00, 8'h00, 16'd0),
            dir_row(8'd98, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'h80, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'h7F, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'h02, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'h00, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'h00, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'hFF, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'h00, 1'b0, bgfr_pkg::EV_NONE,    8'h00, 8'h00, 16'd0),
            dir_row(8'h83, 1'b1, bgfr_pkg::EV_BAD_B,   8'h80, 8'h7F, 16'd2)
        };

        sync1_set[0] = bgfr_pkg::SYNC_FIRST_RST;
        sync2_set[0] = bgfr_pkg::SYNC_SECOND_RST;
        max_set[0]   = bgfr_pkg::MAX_LENGTH_RST;
        sync1_set[1] = 8'h00;           sync2_set[1] = 8'hFF;            max_set[1] = 16'd0;
        sync1_set[2] = 8'hFF;           sync2_set[2] = 8'h00;            max_set[2] = 16'hFFFF;
        sync1_set[3] = 8'hAA;           sync2_set[3] = 8'hAA;            max_set[3] = 16'd8;
        sync1_set[4] = 8'($urandom);    sync2_set[4] = 8'($urandom);
        max_set[4]   = 16'($urandom_range(1, 40));
        sync1_set[5] = bgfr_pkg::SYNC_FIRST_RST;
        sync2_set[5] = bgfr_pkg::SYNC_SECOND_RST;
        max_set[5]   = 16'd1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_rx(dir_rows[i].rx, dir_rows[i].fixed, dir_rows[i].res);

        for (int setting = 0; setting < SETTINGS_COUNT; setting++)
        begin
            if (setting != 0)
            begin
                // hold the stream until every result is back before touching registers
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (frame_results_q.size() != 0) @(posedge clk);
                repeat (4) @(posedge clk);
                write_reg(bgfr_pkg::REG_UNUSED, 16'($urandom));
                write_reg(bgfr_pkg::REG_MAX_LENGTH, max_set[setting]);
                write_reg(bgfr_pkg::REG_SYNC_FIRST, {8'($urandom), sync1_set[setting]});
                write_reg(bgfr_pkg::REG_SYNC_SECOND, {8'($urandom), sync2_set[setting]});
            end
            no_idle  = (setting == 2);
            pass_end = bytes_sent + BYTES_PER_PASS;
            while (bytes_sent < pass_end)
                random_burst();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d bytes over %0d register settings: %0d payload bytes, %0d good frames",
                 bytes_sent, SETTINGS_COUNT, payload_seen, good_seen);
        $display("%0d bad first checks, %0d bad second checks, %0d rejected lengths, %0d mismatches",
                 bad_a_seen, bad_b_seen, rejected_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("binary_gps_frame_receiver_core_tb passed");
        else
            $display("binary_gps_frame_receiver_core_tb failed");
        $finish;
    end

endmodule
